// ===== hw/rtl/grid_line_run_length_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// grid line run-length encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_RUN_LENGTH_ENCODER_MACROS_SVH
`define GRID_LINE_RUN_LENGTH_ENCODER_MACROS_SVH

// same-cycle implication
`define GLRLE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glrle assertion failed");

// next-cycle implication
`define GLRLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glrle assertion failed");

`endif

// ===== hw/rtl/glrle_pkg.sv =====
// ----------------------------------------------------------------------------
// glrle_pkg
// Widths, reset values and codes shared by the run-length encoder files.
// ----------------------------------------------------------------------------
package glrle_pkg;

	// largest grid side supported by default
	localparam int MAX_SIZE_DEF = 64;

	// fixed field widths
	localparam int CFG_W  = 7;
	localparam int LINE_W = 6;
	localparam int RUN_W  = 7;

	// grid size after reset
	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

	// run direction codes
	localparam logic DIR_ROW = 1'b0;
	localparam logic DIR_COL = 1'b1;

endpackage

// ===== hw/rtl/glrle_col_store.sv =====
// ----------------------------------------------------------------------------
// glrle_col_store
// Per-column run counters in a synchronous memory with valid bits and
// write-to-read forwarding for back-to-back accesses to the same column.
// ----------------------------------------------------------------------------
module glrle_col_store #(
	parameter int Depth = glrle_pkg::MAX_SIZE_DEF,
	parameter int CntW  = $clog2(glrle_pkg::MAX_SIZE_DEF + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [CntW-1:0]          wr_data,
	output logic [CntW-1:0]          rd_data
);

	logic [CntW-1:0]  mem_q [Depth];
	logic [Depth-1:0] valid_q;
	logic [CntW-1:0]  rdata_s1;
	logic             vld_s1;
	logic             fwd_s1;
	logic [CntW-1:0]  fwd_data_s1;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	// entry valid bits, an invalid entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// capture valid bit and forward a write landing on the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			vld_s1      <= valid_q[rd_addr];
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// read data seen by the stage after the read
	always_comb begin
		if (fwd_s1) begin
			rd_data = fwd_data_s1;
		end else if (vld_s1) begin
			rd_data = rdata_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ===== hw/rtl/grid_line_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// grid_line_run_length_encoder
// Counts runs of filled cells along rows and down columns of a square grid.
// ----------------------------------------------------------------------------
// Usage:
//   Cells enter on in_valid/in_ready (cell_filled) in raster order; the block
//   tracks row and column itself and wraps to the origin after the last cell.
//   Each ending run leaves on out_valid/out_ready as is_column, line_index,
//   run_length; last_of_item marks the final result of a cell. A cell gives
//   zero, one or two results, a row run before a column run.
//   cfg_wr_en/cfg_wr_data sets the grid side (0 acts as 1, above MaxSize as
//   MaxSize) and starts a new grid with all counters cleared; write it only
//   while idle.
// Throughput: one cell per cycle while out_ready is high and each cell has
//   at most one result; a cell with two results holds the output register
//   until both have left. The column counters sit in one memory read on
//   acceptance and written back as the cell moves to the output stage.
// Reset: grid side 64, position at the origin, all counters zero, with no
//   clearing pass (column counters carry valid bits).
// Stall: a waiting result holds; one more cell is taken into the memory
//   stage, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`include "grid_line_run_length_encoder_macros.svh"

module grid_line_run_length_encoder #(
	parameter int MaxSize = glrle_pkg::MAX_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [glrle_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cell_filled,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_column,
	output logic [glrle_pkg::LINE_W-1:0]  line_index,
	output logic [glrle_pkg::RUN_W-1:0]   run_length,
	output logic                          last_of_item
);

	localparam int IdxW = $clog2(MaxSize);
	localparam int CntW = $clog2(MaxSize + 1);

	logic [glrle_pkg::CFG_W-1:0] size_q;
	logic [IdxW-1:0]             row_q;
	logic [IdxW-1:0]             col_q;
	logic [CntW-1:0]             row_cnt_q;
	logic [CntW-1:0]             side;
	logic                        row_end;
	logic                        bottom;
	logic                        row_emit;
	logic [CntW-1:0]             row_len;
	logic                        in_xfer;
	logic                        out_xfer;

	logic                        s1_v_q;
	logic                        filled_s1;
	logic [IdxW-1:0]             col_s1;
	logic                        bottom_s1;
	logic                        row_emit_s1;
	logic [IdxW-1:0]             row_idx_s1;
	logic [CntW-1:0]             row_len_s1;
	logic                        s1_adv;

	logic [CntW-1:0]             col_old;
	logic [CntW-1:0]             col_len;
	logic [CntW-1:0]             col_new;
	logic                        col_emit;

	logic                        s2_row_q;
	logic                        s2_col_q;
	logic [IdxW-1:0]             row_idx_s2;
	logic [CntW-1:0]             row_len_s2;
	logic [IdxW-1:0]             col_idx_s2;
	logic [CntW-1:0]             col_len_s2;
	logic                        s2_busy;
	logic                        s2_done;

	// side in use
	always_comb begin
		if (int'(size_q) == 0) begin
			side = CntW'(1);
		end else if (int'(size_q) > MaxSize) begin
			side = CntW'(MaxSize);
		end else begin
			side = CntW'(size_q);
		end
	end

	// position and row run at acceptance
	assign row_end  = (CntW'(col_q) == side - CntW'(1));
	assign bottom   = (CntW'(row_q) == side - CntW'(1));
	assign row_emit = cell_filled ? row_end : (row_cnt_q != '0);
	assign row_len  = cell_filled ? row_cnt_q + CntW'(1) : row_cnt_q;

	// handshakes and stage advance
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign s2_busy  = s2_row_q || s2_col_q;
	assign s2_done  = out_xfer && last_of_item;
	assign s1_adv   = s1_v_q && (!s2_busy || s2_done);
	assign in_ready = !s1_v_q || s1_adv;

	// column counter memory
	glrle_col_store #(
		.Depth (MaxSize),
		.CntW  (CntW)
	) u_col_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_wr_en),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (col_new),
		.rd_data (col_old)
	);

	// column run update
	assign col_emit = filled_s1 ? bottom_s1 : (col_old != '0);
	assign col_len  = filled_s1 ? col_old + CntW'(1) : col_old;
	assign col_new  = (filled_s1 && !bottom_s1) ? col_old + CntW'(1) : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= glrle_pkg::SIZE_RESET;
			row_q     <= '0;
			col_q     <= '0;
			row_cnt_q <= '0;
			s1_v_q    <= 1'b0;
			s2_row_q  <= 1'b0;
			s2_col_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q    <= cfg_wr_data;
				row_q     <= '0;
				col_q     <= '0;
				row_cnt_q <= '0;
			end else if (in_xfer) begin
				row_cnt_q <= (cell_filled && !row_end) ? row_cnt_q + CntW'(1) : '0;
				if (row_end) begin
					col_q <= '0;
					row_q <= bottom ? '0 : row_q + IdxW'(1);
				end else begin
					col_q <= col_q + IdxW'(1);
				end
			end
			if (in_xfer) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_row_q <= row_emit_s1;
				s2_col_q <= col_emit;
			end else if (out_xfer) begin
				if (s2_row_q) begin
					s2_row_q <= 1'b0;
				end else begin
					s2_col_q <= 1'b0;
				end
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			filled_s1   <= cell_filled;
			col_s1      <= col_q;
			bottom_s1   <= bottom;
			row_emit_s1 <= row_emit;
			row_idx_s1  <= row_q;
			row_len_s1  <= row_len;
		end
		if (s1_adv) begin
			row_idx_s2 <= row_idx_s1;
			row_len_s2 <= row_len_s1;
			col_idx_s2 <= col_s1;
			col_len_s2 <= col_len;
		end
	end

	// result output, row run first
	assign out_valid    = s2_busy;
	assign is_column    = s2_row_q ? glrle_pkg::DIR_ROW : glrle_pkg::DIR_COL;
	assign line_index   = glrle_pkg::LINE_W'(s2_row_q ? row_idx_s2 : col_idx_s2);
	assign run_length   = glrle_pkg::RUN_W'(s2_row_q ? row_len_s2 : col_len_s2);
	assign last_of_item = !(s2_row_q && s2_col_q);

	// checks
	`GLRLE_ASSERT_NOW(a_pair_row_first, s2_row_q && s2_col_q, !is_column && !last_of_item)
	`GLRLE_ASSERT_NOW(a_run_nonzero, out_valid, run_length != '0)
	`GLRLE_ASSERT_NEXT(a_cfg_origin, cfg_wr_en, row_q == '0 && col_q == '0 && row_cnt_q == '0)
	`GLRLE_ASSERT_NOW(a_stall_cause, !in_ready, s1_v_q && s2_busy && !s2_done)

endmodule
